### rtl/rbmf_pkg.sv
// Shared types, widths and codes for the rigid-body momentum pipeline.
// No dependencies; used by rbmf_sqrt and rigid_body_momentum_frames_top.
package rbmf_pkg;

    localparam int IN_W   = 32;
    localparam int VEC_W  = 49;
    localparam int ROT_W  = 36;
    localparam int OP_W   = 50;
    localparam int HALF_W = 25;
    localparam int SUM_W  = 102;
    localparam int ROOT_W = 49;
    localparam int OUT_W  = 48;
    localparam int IDX_W  = 3;
    localparam int SEL_W  = 4;

    localparam logic [IDX_W-1:0] REG_SEL  = 3'd0;
    localparam logic [IDX_W-1:0] REG_MASS = 3'd1;
    localparam logic [IDX_W-1:0] REG_IXX  = 3'd2;
    localparam logic [IDX_W-1:0] REG_IYY  = 3'd3;
    localparam logic [IDX_W-1:0] REG_IZZ  = 3'd4;
    localparam logic [IDX_W-1:0] REG_IXZ  = 3'd5;
    localparam logic [IDX_W-1:0] REG_IZX  = 3'd6;

    localparam logic [SEL_W-1:0] SEL_LIN_U   = 4'd0;
    localparam logic [SEL_W-1:0] SEL_LIN_W   = 4'd2;
    localparam logic [SEL_W-1:0] SEL_LIN_MAG = 4'd3;
    localparam logic [SEL_W-1:0] SEL_ANG_P   = 4'd4;
    localparam logic [SEL_W-1:0] SEL_ANG_R   = 4'd6;
    localparam logic [SEL_W-1:0] SEL_ANG_MAG = 4'd7;
    localparam logic [SEL_W-1:0] SEL_LIN_N   = 4'd8;
    localparam logic [SEL_W-1:0] SEL_LIN_D   = 4'd10;
    localparam logic [SEL_W-1:0] SEL_ANG_N   = 4'd11;
    localparam logic [SEL_W-1:0] SEL_ANG_D   = 4'd13;

    localparam logic [IN_W-1:0] ONE_Q16 = 32'h0001_0000;

    localparam logic [OUT_W-1:0] POS48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] NEG48 = 48'h8000_0000_0000;

    typedef enum logic [1:0] {
        K_DIRECT  = 2'd0,
        K_FRAME   = 2'd1,
        K_MAG_LIN = 2'd2,
        K_MAG_ANG = 2'd3
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_ctl;

endpackage

### rtl/rbmf_sqrt.sv
// Pipelined floor square root, one root bit per stage; non-magnitude requests
// pass their value through unchanged. Depends on rbmf_pkg.
module rbmf_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rbmf_pkg::t_ctl               i_ctl,
    input  logic [rbmf_pkg::SUM_W-1:0]   i_rad,
    output rbmf_pkg::t_ctl               o_ctl,
    output logic [rbmf_pkg::SUM_W-1:0]   o_rad,
    output logic [rbmf_pkg::ROOT_W-1:0]  o_root
);

    localparam int N = rbmf_pkg::ROOT_W;
    localparam int W = rbmf_pkg::SUM_W;

    rbmf_pkg::t_ctl r_ctl  [N];
    logic [W-1:0]   r_rem  [N];
    logic [N-1:0]   r_root [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam int B = N - 1 - s;
        rbmf_pkg::t_ctl w_ctl;
        logic [W-1:0]   w_rem;
        logic [N-1:0]   w_root;
        logic [W-1:0]   w_trial;
        logic           w_take;

        if (s == 0) begin : g_first
            assign w_ctl  = i_ctl;
            assign w_rem  = i_rad;
            assign w_root = '0;
        end else begin : g_next
            assign w_ctl  = r_ctl[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_root = r_root[s-1];
        end

        assign w_trial = ({{(W-N){1'b0}}, w_root} << (B + 1))
                       | ({{(W-1){1'b0}}, 1'b1} << (2 * B));
        assign w_take  = (w_ctl.kind == rbmf_pkg::K_MAG_LIN ||
                          w_ctl.kind == rbmf_pkg::K_MAG_ANG) && (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s] <= '0;
            end else begin
                r_ctl[s] <= w_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= w_take ? (w_rem - w_trial) : w_rem;
            r_root[s] <= w_take ? (w_root | ({{(N-1){1'b0}}, 1'b1} << B)) : w_root;
        end
    end

    assign o_ctl  = r_ctl[N-1];
    assign o_rad  = r_rem[N-1];
    assign o_root = r_root[N-1];

    logic w_out_mag;
    assign w_out_mag = (o_ctl.kind == rbmf_pkg::K_MAG_LIN) ||
                       (o_ctl.kind == rbmf_pkg::K_MAG_ANG);

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.valid && w_out_mag) |-> (o_rad <= {{(W-N-1){1'b0}}, o_root, 1'b0}))
        else $error("square root remainder exceeds twice the root");

    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.valid && !w_out_mag) |-> (o_rad == $past(i_rad, N) && o_root == '0))
        else $error("pass-through value altered in root pipeline");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.valid |-> (o_ctl.kind == $past(i_ctl.kind, N)))
        else $error("request kind changed in root pipeline");

endmodule

### rtl/rigid_body_momentum_frames_top.sv
// Rigid-body momentum pipeline: products, operand select, dot product,
// square root, mass scale and saturation. Depends on rbmf_pkg and rbmf_sqrt.
//
// Usage:
//  Input: a request is taken at each rising edge with i_start high and
//  o_busy low; o_busy stays low, so one request can enter every cycle.
//  Output: each request gives one result, shown for one cycle with o_done
//  high; the receiver cannot stall it.
//  Throughput is one result per cycle, set by the fully pipelined multiply
//  lanes and the 49-stage root pipeline (one root bit per stage).
//  Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at the
//  next edge; write only while no request is in flight. Index 0 selects
//  the quantity, 1 mass, 2..6 inertia xx, yy, zz, xz, zx; index 7 is ignored.
//  Reset: synchronous on i_rst_n low; drops every request in flight and
//  restores the register defaults (unit mass and inertia diagonal).
module rigid_body_momentum_frames_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic signed [rbmf_pkg::IN_W-1:0] i_velocity_u,
    input  logic signed [rbmf_pkg::IN_W-1:0] i_velocity_v,
    input  logic signed [rbmf_pkg::IN_W-1:0] i_velocity_w,
    input  logic signed [rbmf_pkg::IN_W-1:0] i_rate_p,
    input  logic signed [rbmf_pkg::IN_W-1:0] i_rate_q,
    input  logic signed [rbmf_pkg::IN_W-1:0] i_rate_r,
    input  logic signed [rbmf_pkg::IN_W-1:0] i_quat_e0,
    input  logic signed [rbmf_pkg::IN_W-1:0] i_quat_e1,
    input  logic signed [rbmf_pkg::IN_W-1:0] i_quat_e2,
    input  logic signed [rbmf_pkg::IN_W-1:0] i_quat_e3,
    input  logic                             i_cfg_we,
    input  logic [rbmf_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [rbmf_pkg::IN_W-1:0]        i_cfg_data,
    output logic                             o_done,
    output logic signed [rbmf_pkg::OUT_W-1:0] o_momentum_value,
    output logic                             o_saturated
);

    localparam int IW = rbmf_pkg::IN_W;
    localparam int VW = rbmf_pkg::VEC_W;
    localparam int RW = rbmf_pkg::ROT_W;
    localparam int OW = rbmf_pkg::OP_W;
    localparam int HW = rbmf_pkg::HALF_W;
    localparam int SW = rbmf_pkg::SUM_W;
    localparam int QW = rbmf_pkg::ROOT_W;
    localparam int YW = rbmf_pkg::OUT_W;

    function automatic logic [RW-1:0] sx34(input logic [33:0] a);
        return {{(RW-34){a[33]}}, a};
    endfunction

    function automatic logic [OW-1:0] ext_vec(input logic [VW-1:0] a);
        return {{(OW-VW){a[VW-1]}}, a};
    endfunction

    function automatic logic [OW-1:0] ext_rot(input logic [RW-1:0] a);
        return {{(OW-RW){a[RW-1]}}, a};
    endfunction

    function automatic logic [OW-1:0] ext_in(input logic [IW-1:0] a);
        return {{(OW-IW){a[IW-1]}}, a};
    endfunction

    assign o_busy = 1'b0;

    // configuration registers
    logic [rbmf_pkg::SEL_W-1:0] r_sel;
    logic [IW-1:0]              r_mass;
    logic signed [IW-1:0]       r_ixx, r_iyy, r_izz, r_ixz, r_izx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= '0;
            r_mass <= rbmf_pkg::ONE_Q16;
            r_ixx  <= rbmf_pkg::ONE_Q16;
            r_iyy  <= rbmf_pkg::ONE_Q16;
            r_izz  <= rbmf_pkg::ONE_Q16;
            r_ixz  <= '0;
            r_izx  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbmf_pkg::REG_SEL:  r_sel  <= i_cfg_data[rbmf_pkg::SEL_W-1:0];
                rbmf_pkg::REG_MASS: r_mass <= i_cfg_data;
                rbmf_pkg::REG_IXX:  r_ixx  <= i_cfg_data;
                rbmf_pkg::REG_IYY:  r_iyy  <= i_cfg_data;
                rbmf_pkg::REG_IZZ:  r_izz  <= i_cfg_data;
                rbmf_pkg::REG_IXZ:  r_ixz  <= i_cfg_data;
                rbmf_pkg::REG_IZX:  r_izx  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain, stages 1 to 3
    logic r_v1, r_v2, r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start && !o_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: capture request
    logic signed [IW-1:0] r_vel1 [3];
    logic signed [IW-1:0] r_rate1 [3];
    logic signed [IW-1:0] r_e1 [4];

    always_ff @(posedge i_clk) begin
        r_vel1[0]  <= i_velocity_u;
        r_vel1[1]  <= i_velocity_v;
        r_vel1[2]  <= i_velocity_w;
        r_rate1[0] <= i_rate_p;
        r_rate1[1] <= i_rate_q;
        r_rate1[2] <= i_rate_r;
        r_e1[0]    <= i_quat_e0;
        r_e1[1]    <= i_quat_e1;
        r_e1[2]    <= i_quat_e2;
        r_e1[3]    <= i_quat_e3;
    end

    // stage 2: products
    logic signed [2*IW:0]   r_pl [3];
    logic signed [2*IW-1:0] r_pxx, r_pxz, r_pyy, r_pzx, r_pzz;
    logic signed [2*IW-1:0] r_s0, r_s1, r_s2, r_s3;
    logic signed [2*IW-1:0] r_m12, r_m30, r_m13, r_m20, r_m23, r_m10;
    logic [IW-1:0]          r_vel2 [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pl[i]   <= $signed({1'b0, r_mass}) * r_vel1[i];
            r_vel2[i] <= r_vel1[i];
        end
        r_pxx <= r_ixx * r_rate1[0];
        r_pxz <= r_ixz * r_rate1[2];
        r_pyy <= r_iyy * r_rate1[1];
        r_pzx <= r_izx * r_rate1[0];
        r_pzz <= r_izz * r_rate1[2];
        r_s0  <= r_e1[0] * r_e1[0];
        r_s1  <= r_e1[1] * r_e1[1];
        r_s2  <= r_e1[2] * r_e1[2];
        r_s3  <= r_e1[3] * r_e1[3];
        r_m12 <= r_e1[1] * r_e1[2];
        r_m30 <= r_e1[3] * r_e1[0];
        r_m13 <= r_e1[1] * r_e1[3];
        r_m20 <= r_e1[2] * r_e1[0];
        r_m23 <= r_e1[2] * r_e1[3];
        r_m10 <= r_e1[1] * r_e1[0];
    end

    // stage 3: floor shifts, body vectors and rotation matrix
    logic [VW-1:0] r_lin [3];
    logic [VW-1:0] r_ang [3];
    logic [RW-1:0] r_rot [9];
    logic [IW-1:0] r_vel3 [3];

    logic [RW-1:0] w_s0, w_s1, w_s2, w_s3;
    logic [RW-1:0] w_m12, w_m30, w_m13, w_m20, w_m23, w_m10;
    logic [RW-1:0] w_d1, w_d2, w_d3, w_d5, w_d6, w_d7;

    assign w_s0  = sx34(r_s0[63:30]);
    assign w_s1  = sx34(r_s1[63:30]);
    assign w_s2  = sx34(r_s2[63:30]);
    assign w_s3  = sx34(r_s3[63:30]);
    assign w_m12 = sx34(r_m12[63:30]);
    assign w_m30 = sx34(r_m30[63:30]);
    assign w_m13 = sx34(r_m13[63:30]);
    assign w_m20 = sx34(r_m20[63:30]);
    assign w_m23 = sx34(r_m23[63:30]);
    assign w_m10 = sx34(r_m10[63:30]);
    assign w_d1  = w_m12 - w_m30;
    assign w_d2  = w_m13 + w_m20;
    assign w_d3  = w_m12 + w_m30;
    assign w_d5  = w_m23 - w_m10;
    assign w_d6  = w_m13 - w_m20;
    assign w_d7  = w_m23 + w_m10;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_lin[i]  <= r_pl[i][2*IW:16];
            r_vel3[i] <= r_vel2[i];
        end
        r_ang[0] <= {r_pxx[63], r_pxx[63:16]} + {r_pxz[63], r_pxz[63:16]};
        r_ang[1] <= {r_pyy[63], r_pyy[63:16]};
        r_ang[2] <= {r_pzx[63], r_pzx[63:16]} + {r_pzz[63], r_pzz[63:16]};
        r_rot[0] <= w_s1 + w_s0 - w_s2 - w_s3;
        r_rot[1] <= {w_d1[RW-2:0], 1'b0};
        r_rot[2] <= {w_d2[RW-2:0], 1'b0};
        r_rot[3] <= {w_d3[RW-2:0], 1'b0};
        r_rot[4] <= w_s2 + w_s0 - w_s1 - w_s3;
        r_rot[5] <= {w_d5[RW-2:0], 1'b0};
        r_rot[6] <= {w_d6[RW-2:0], 1'b0};
        r_rot[7] <= {w_d7[RW-2:0], 1'b0};
        r_rot[8] <= w_s3 + w_s0 - w_s1 - w_s2;
    end

    // stage 4: operand select for the shared dot product
    logic [OW-1:0]        n_a [3];
    logic [OW-1:0]        n_b [3];
    rbmf_pkg::t_kind      n_kind;
    logic [rbmf_pkg::SEL_W-1:0] w_row_full;
    logic [1:0]           w_row;
    logic [RW-1:0]        w_rc [3];

    assign w_row_full = (r_sel >= rbmf_pkg::SEL_ANG_N) ? (r_sel - rbmf_pkg::SEL_ANG_N)
                                                       : (r_sel - rbmf_pkg::SEL_LIN_N);
    assign w_row = w_row_full[1:0];

    always_comb begin
        w_rc[0] = r_rot[0];
        w_rc[1] = r_rot[1];
        w_rc[2] = r_rot[2];
        case (w_row)
            2'd1: begin
                w_rc[0] = r_rot[3];
                w_rc[1] = r_rot[4];
                w_rc[2] = r_rot[5];
            end
            2'd2: begin
                w_rc[0] = r_rot[6];
                w_rc[1] = r_rot[7];
                w_rc[2] = r_rot[8];
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a[i] = '0;
            n_b[i] = '0;
        end
        n_kind = rbmf_pkg::K_DIRECT;
        unique case (r_sel) inside
            [rbmf_pkg::SEL_LIN_U:rbmf_pkg::SEL_LIN_W]: begin
                n_a[0] = ext_vec(r_lin[r_sel[1:0]]);
                n_b[0] = {{(OW-1){1'b0}}, 1'b1};
            end
            rbmf_pkg::SEL_LIN_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    n_a[i] = ext_in(r_vel3[i]);
                    n_b[i] = ext_in(r_vel3[i]);
                end
                n_kind = rbmf_pkg::K_MAG_LIN;
            end
            [rbmf_pkg::SEL_ANG_P:rbmf_pkg::SEL_ANG_R]: begin
                n_a[0] = ext_vec(r_ang[r_sel[1:0]]);
                n_b[0] = {{(OW-1){1'b0}}, 1'b1};
            end
            rbmf_pkg::SEL_ANG_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    n_a[i] = ext_vec(r_ang[i]);
                    n_b[i] = ext_vec(r_ang[i]);
                end
                n_kind = rbmf_pkg::K_MAG_ANG;
            end
            [rbmf_pkg::SEL_LIN_N:rbmf_pkg::SEL_LIN_D]: begin
                for (int i = 0; i < 3; i++) begin
                    n_a[i] = ext_rot(w_rc[i]);
                    n_b[i] = ext_vec(r_lin[i]);
                end
                n_kind = rbmf_pkg::K_FRAME;
            end
            [rbmf_pkg::SEL_ANG_N:rbmf_pkg::SEL_ANG_D]: begin
                for (int i = 0; i < 3; i++) begin
                    n_a[i] = ext_rot(w_rc[i]);
                    n_b[i] = ext_vec(r_ang[i]);
                end
                n_kind = rbmf_pkg::K_FRAME;
            end
            default: ;
        endcase
    end

    rbmf_pkg::t_ctl r_ctl4, r_ctl5, r_ctl6, r_ctl7;
    logic [OW-1:0]  r_a [3];
    logic [OW-1:0]  r_b [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl4 <= '0;
            r_ctl5 <= '0;
            r_ctl6 <= '0;
            r_ctl7 <= '0;
        end else begin
            r_ctl4 <= '{valid: r_v3, kind: n_kind};
            r_ctl5 <= r_ctl4;
            r_ctl6 <= r_ctl5;
            r_ctl7 <= r_ctl6;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a[i] <= n_a[i];
            r_b[i] <= n_b[i];
        end
    end

    // stage 5: split partial products
    logic [2*HW-1:0]        r_pll [3];
    logic signed [2*HW:0]   r_plh [3];
    logic signed [2*HW:0]   r_phl [3];
    logic signed [2*HW-1:0] r_phh [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pll[i] <= {{HW{1'b0}}, r_a[i][HW-1:0]} * {{HW{1'b0}}, r_b[i][HW-1:0]};
            r_plh[i] <= $signed({1'b0, r_a[i][HW-1:0]}) * $signed(r_b[i][OW-1:HW]);
            r_phl[i] <= $signed(r_a[i][OW-1:HW]) * $signed({1'b0, r_b[i][HW-1:0]});
            r_phh[i] <= $signed(r_a[i][OW-1:HW]) * $signed(r_b[i][OW-1:HW]);
        end
    end

    // stage 6: recombine products
    logic [SW-1:0] r_prod [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_prod[i] <= {{(SW-2*HW){1'b0}}, r_pll[i]}
                       + ({{(SW-2*HW-1){r_plh[i][2*HW]}}, r_plh[i]} << HW)
                       + ({{(SW-2*HW-1){r_phl[i][2*HW]}}, r_phl[i]} << HW)
                       + ({{(SW-2*HW){r_phh[i][2*HW-1]}}, r_phh[i]} << (2*HW));
        end
    end

    // stage 7: dot product sum
    logic [SW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        r_sum <= r_prod[0] + r_prod[1] + r_prod[2];
    end

    rbmf_pkg::t_ctl w_sq_ctl;
    logic [SW-1:0]  w_sq_rad;
    logic [QW-1:0]  w_sq_root;

    rbmf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl7),
        .i_rad   (r_sum),
        .o_ctl   (w_sq_ctl),
        .o_rad   (w_sq_rad),
        .o_root  (w_sq_root)
    );

    // post stage 1: mass scale partials and pass value
    rbmf_pkg::t_ctl    r_ctl_p1, r_ctl_p2;
    logic [IW+HW-1:0]  r_mlo;
    logic [IW+QW-HW-1:0] r_mhi;
    logic [SW-1:0]     r_pv;

    always_ff @(posedge i_clk) begin
        r_mlo <= {{HW{1'b0}}, r_mass} * {{IW{1'b0}}, w_sq_root[HW-1:0]};
        r_mhi <= {{(QW-HW){1'b0}}, r_mass} * {{IW{1'b0}}, w_sq_root[QW-1:HW]};
        case (w_sq_ctl.kind)
            rbmf_pkg::K_FRAME:   r_pv <= {{30{w_sq_rad[SW-1]}}, w_sq_rad[SW-1:30]};
            rbmf_pkg::K_MAG_ANG: r_pv <= {{(SW-QW){1'b0}}, w_sq_root};
            default:             r_pv <= w_sq_rad;
        endcase
    end

    // post stage 2: combine mass scale and select the result value
    logic [SW-1:0] r_val;
    logic [SW-1:0] w_mscale;

    assign w_mscale = {{(SW-IW-HW){1'b0}}, r_mlo}
                    + ({{(SW-IW-QW+HW){1'b0}}, r_mhi} << HW);

    always_ff @(posedge i_clk) begin
        r_val <= (r_ctl_p1.kind == rbmf_pkg::K_MAG_LIN) ? (w_mscale >> 16) : r_pv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_p1 <= '0;
            r_ctl_p2 <= '0;
            o_done   <= 1'b0;
        end else begin
            r_ctl_p1 <= w_sq_ctl;
            r_ctl_p2 <= r_ctl_p1;
            o_done   <= r_ctl_p2.valid;
        end
    end

    // post stage 3: saturate
    logic w_fits;

    assign w_fits = (&r_val[SW-1:YW-1]) || !(|r_val[SW-1:YW-1]);

    always_ff @(posedge i_clk) begin
        o_saturated <= r_ctl_p2.valid && !w_fits;
        if (w_fits) begin
            o_momentum_value <= r_val[YW-1:0];
        end else begin
            o_momentum_value <= r_val[SW-1] ? rbmf_pkg::NEG48 : rbmf_pkg::POS48;
        end
    end

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |->
        (o_momentum_value == rbmf_pkg::POS48 || o_momentum_value == rbmf_pkg::NEG48))
        else $error("saturated result not at a bound");

    a_sat_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> o_done)
        else $error("saturation flag without result");

    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised on a pipeline that never stalls");

endmodule
